@@ rtl/xsed_pkg.sv @@
// Shared types and constants of the cross-reference stream entry decoder.
`default_nettype none
package xsed_pkg;

   localparam int OBJ_W      = 12;
   localparam int WIDTH_W    = 4;
   localparam int VALUE_W    = 64;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int OBJ_SPACE  = 2 ** OBJ_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH_TYPE,
      REG_WIDTH_SECOND,
      REG_WIDTH_THIRD,
      REG_FIRST_OBJECT,
      REG_LAST_OBJECT
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_FREE,
      KIND_IN_USE,
      KIND_COMPRESSED
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_STORED,
      STATUS_BAD_TYPE,
      STATUS_OUT_OF_RANGE,
      STATUS_SKIPPED
   } status_type;

   typedef struct packed {
      logic [OBJ_W-1:0]   object_number;
      logic [1:0]         kind;
      logic               bad_type;
      logic               out_of_range;
      logic               section_end;
      logic [VALUE_W-1:0] second_value;
      logic [VALUE_W-1:0] third_value;
   } entry_type;

   typedef struct packed {
      logic [OBJ_W-1:0]   object_number;
      logic [1:0]         entry_kind;
      logic [VALUE_W-1:0] second_value;
      logic [VALUE_W-1:0] third_value;
      logic [1:0]         status;
      logic               section_end;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/xsed_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xsed_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/xsed_fifo.sv @@
// Two-entry register queue for decoder entries and results.
`default_nettype none
module xsed_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("transfer pushed into a full queue");
`endif

endmodule
`default_nettype wire

@@ rtl/xsed_front.sv @@
// Front end: section registers, byte assembly into entries and entry classification.
`default_nettype none
module xsed_front import xsed_pkg::*; #(
   parameter int MAX_OBJECTS     = 4096,
   parameter int MAX_FIELD_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  in_valid,
   input  wire logic [BYTE_W-1:0]     data_byte,
   output logic                       entry_push,
   output entry_type                  entry,
   output logic                       restart
);

   localparam logic [WIDTH_W-1:0] MAX_W     = WIDTH_W'(MAX_FIELD_BYTES);
   localparam logic [31:0]        MAX_OBJ_L = 32'(MAX_OBJECTS);

   logic [WIDTH_W-1:0] width_type_ff, width_type_in;
   logic [WIDTH_W-1:0] width_second_ff, width_second_in;
   logic [WIDTH_W-1:0] width_third_ff, width_third_in;
   logic [OBJ_W-1:0]   first_object_ff, first_object_in;
   logic [OBJ_W-1:0]   last_object_ff, last_object_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] acc_type_ff, acc_type_in;
   logic [VALUE_W-1:0] acc_second_ff, acc_second_in;
   logic [VALUE_W-1:0] acc_third_ff, acc_third_in;
   logic [OBJ_W-1:0]   obj_ff, obj_in;
   logic               halted_ff, halted_in;

   logic [WIDTH_W-1:0] wt, ws, w3;
   logic [POS_W-1:0]   wt5, ts5, total;
   logic [POS_W-1:0]   pos_nx;
   logic [VALUE_W-1:0] acc_type_nx, acc_second_nx, acc_third_nx;
   logic [VALUE_W-1:0] type_val;
   logic               done;
   logic               cfg_hit;

   // clamp field widths
   always_comb begin
      wt    = (width_type_ff   > MAX_W) ? MAX_W : width_type_ff;
      ws    = (width_second_ff > MAX_W) ? MAX_W : width_second_ff;
      w3    = (width_third_ff  > MAX_W) ? MAX_W : width_third_ff;
      wt5   = POS_W'(wt);
      ts5   = POS_W'(wt) + POS_W'(ws);
      total = ts5 + POS_W'(w3);
   end

   // shift the byte into its field
   always_comb begin
      acc_type_nx   = acc_type_ff;
      acc_second_nx = acc_second_ff;
      acc_third_nx  = acc_third_ff;
      if (total != '0) begin
         if (pos_ff < wt5) begin
            acc_type_nx = {acc_type_ff[VALUE_W-BYTE_W-1:0], data_byte};
         end else if (pos_ff < ts5) begin
            acc_second_nx = {acc_second_ff[VALUE_W-BYTE_W-1:0], data_byte};
         end else begin
            acc_third_nx = {acc_third_ff[VALUE_W-BYTE_W-1:0], data_byte};
         end
      end
      pos_nx = pos_ff + POS_W'(1);
      done   = (total == '0) || (pos_nx == total);
   end

   // classify the completed entry
   always_comb begin
      type_val            = (wt == '0) ? VALUE_W'(1) : acc_type_nx;
      entry.object_number = obj_ff;
      entry.bad_type      = (type_val > VALUE_W'(2));
      entry.kind          = entry.bad_type ? KIND_FREE : type_val[1:0];
      entry.out_of_range  = (32'(obj_ff) >= MAX_OBJ_L);
      entry.section_end   = (obj_ff == last_object_ff);
      entry.second_value  = acc_second_nx;
      entry.third_value   = acc_third_nx;
   end

   always_comb begin
      width_type_in   = width_type_ff;
      width_second_in = width_second_ff;
      width_third_in  = width_third_ff;
      first_object_in = first_object_ff;
      last_object_in  = last_object_ff;
      cfg_hit         = csr_we;
      case (csr_index)
         REG_WIDTH_TYPE:   width_type_in   = csr_wdata[WIDTH_W-1:0];
         REG_WIDTH_SECOND: width_second_in = csr_wdata[WIDTH_W-1:0];
         REG_WIDTH_THIRD:  width_third_in  = csr_wdata[WIDTH_W-1:0];
         REG_FIRST_OBJECT: first_object_in = csr_wdata[OBJ_W-1:0];
         REG_LAST_OBJECT:  last_object_in  = csr_wdata[OBJ_W-1:0];
         default:          cfg_hit         = 1'b0;
      endcase
      if (!csr_we) begin
         width_type_in   = width_type_ff;
         width_second_in = width_second_ff;
         width_third_in  = width_third_ff;
         first_object_in = first_object_ff;
         last_object_in  = last_object_ff;
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      acc_type_in   = acc_type_ff;
      acc_second_in = acc_second_ff;
      acc_third_in  = acc_third_ff;
      obj_in        = obj_ff;
      halted_in     = halted_ff;
      entry_push    = 1'b0;
      if (cfg_hit) begin
         pos_in        = '0;
         acc_type_in   = '0;
         acc_second_in = '0;
         acc_third_in  = '0;
         obj_in        = first_object_in;
         halted_in     = (first_object_in > last_object_in);
      end else if (in_valid && !halted_ff) begin
         if (done) begin
            entry_push    = 1'b1;
            pos_in        = '0;
            acc_type_in   = '0;
            acc_second_in = '0;
            acc_third_in  = '0;
            if ((obj_ff >= last_object_ff) || entry.out_of_range) begin
               halted_in = 1'b1;
            end else begin
               obj_in = obj_ff + OBJ_W'(1);
            end
         end else begin
            pos_in        = pos_nx;
            acc_type_in   = acc_type_nx;
            acc_second_in = acc_second_nx;
            acc_third_in  = acc_third_nx;
         end
      end
   end

   assign restart = cfg_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_type_ff   <= WIDTH_W'(1);
         width_second_ff <= WIDTH_W'(4);
         width_third_ff  <= WIDTH_W'(2);
         first_object_ff <= '0;
         last_object_ff  <= '0;
         pos_ff          <= '0;
         acc_type_ff     <= '0;
         acc_second_ff   <= '0;
         acc_third_ff    <= '0;
         obj_ff          <= '0;
         halted_ff       <= 1'b0;
      end else begin
         width_type_ff   <= width_type_in;
         width_second_ff <= width_second_in;
         width_third_ff  <= width_third_in;
         first_object_ff <= first_object_in;
         last_object_ff  <= last_object_in;
         pos_ff          <= pos_in;
         acc_type_ff     <= acc_type_in;
         acc_second_ff   <= acc_second_in;
         acc_third_ff    <= acc_third_in;
         obj_ff          <= obj_in;
         halted_ff       <= halted_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/xsed_back.sv @@
// Back end: defined-object map lookup and update, status and result issue.
`default_nettype none
module xsed_back import xsed_pkg::*; #(
   parameter int MAX_OBJECTS = 4096
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      restart,
   input  wire logic      ent_valid,
   input  wire entry_type ent,
   output logic           ent_pop,
   output logic           rsp_push,
   output rsp_type        rsp,
   input  wire logic      rsp_full,
   output logic           clearing
);

   localparam int MAP_DEPTH = (MAX_OBJECTS < OBJ_SPACE) ? MAX_OBJECTS : OBJ_SPACE;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam logic [MAP_AW-1:0] MAP_LAST = MAP_AW'(MAP_DEPTH - 1);

   logic              clr_ff, clr_in;
   logic [MAP_AW-1:0] clr_addr_ff, clr_addr_in;
   logic              st2_valid_ff, st2_valid_in;
   entry_type         st2_ff;
   logic              drop_ff, drop_in;

   logic              st2_go;
   logic              st2_free;
   logic              defined;
   status_type        status;
   logic              map_we;
   logic [MAP_AW-1:0] map_waddr;
   logic              map_wdata;

   assign st2_go   = st2_valid_ff && (drop_ff || !rsp_full);
   assign st2_free = !st2_valid_ff || st2_go;
   assign ent_pop  = ent_valid && st2_free && !clr_ff;
   assign clearing = clr_ff;

   xsed_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (ent_pop),
      .rd_addr (ent.object_number[MAP_AW-1:0]),
      .rd_data (defined)
   );

   always_comb begin
      if (st2_ff.out_of_range) begin
         status = STATUS_OUT_OF_RANGE;
      end else if (defined) begin
         status = STATUS_SKIPPED;
      end else if (st2_ff.bad_type) begin
         status = STATUS_BAD_TYPE;
      end else begin
         status = STATUS_STORED;
      end
      rsp_push           = st2_go && !drop_ff;
      rsp.object_number  = st2_ff.object_number;
      rsp.entry_kind     = st2_ff.kind;
      rsp.second_value   = st2_ff.second_value;
      rsp.third_value    = st2_ff.third_value;
      rsp.status         = status;
      rsp.section_end    = st2_ff.section_end;
   end

   always_comb begin
      if (clr_ff) begin
         map_we    = 1'b1;
         map_waddr = clr_addr_ff;
         map_wdata = 1'b0;
      end else begin
         map_we    = rsp_push && (status == STATUS_STORED);
         map_waddr = st2_ff.object_number[MAP_AW-1:0];
         map_wdata = 1'b1;
      end
   end

   always_comb begin
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + MAP_AW'(1);
         clr_in      = (clr_addr_ff != MAP_LAST);
      end
      st2_valid_in = st2_valid_ff;
      if (ent_pop) begin
         st2_valid_in = 1'b1;
      end else if (st2_go) begin
         st2_valid_in = 1'b0;
      end
      drop_in = drop_ff;
      if (restart) begin
         drop_in = 1'b0;
      end else if (rsp_push &&
                   (status == STATUS_BAD_TYPE || status == STATUS_OUT_OF_RANGE)) begin
         drop_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         st2_valid_ff <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         st2_valid_ff <= st2_valid_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_pop) begin
         st2_ff <= ent;
      end
   end

`ifndef SYNTHESIS
   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !(clr_ff && (st2_valid_ff || ent_pop)))
      else $error("entry in flight during map clearing");
   a_halt_after_bad_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && status == STATUS_BAD_TYPE && !restart) |=> drop_ff)
      else $error("bad type did not stop the section");
   a_drop_never_writes: assert property (@(posedge clock) disable iff (reset)
      (drop_ff && !clr_ff) |-> !map_we)
      else $error("dropped entry wrote the map");
`endif

endmodule
`default_nettype wire

@@ rtl/xref_stream_entry_decoder.sv @@
// Top level of the cross-reference stream entry decoder.
// Takes one stream byte per cycle while req_full is low and returns one result per
// completed entry, through the one that stops its section. The front end assembles the
// three big-endian fields and classifies the entry; a two-entry queue decouples it from
// the back end, which reads the defined-object map (one read and one write per cycle),
// sets the status and writes the result into a two-entry output queue. Sustained rate
// is one byte per cycle while req_full is low; a result passes the entry queue, the
// back-end stage register and output queue on its way to the result ports. After reset
// the map is cleared one entry a cycle, while req_full stays high; configuration writes
// are taken at any time. Bytes that arrive after a section stops (last object, bad type,
// object out of range) are taken and dropped until a section register is written.
`default_nettype none
module xref_stream_entry_decoder import xsed_pkg::*; #(
   parameter int MAX_OBJECTS     = 4096,
   parameter int MAX_FIELD_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_push,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   output logic                       req_full,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic      [OBJ_W-1:0]      rsp_object_number,
   output logic      [1:0]            rsp_entry_kind,
   output logic      [VALUE_W-1:0]    rsp_second_value,
   output logic      [VALUE_W-1:0]    rsp_third_value,
   output logic      [1:0]            rsp_status,
   output logic                       rsp_section_end
);

   logic      accept;
   logic      entry_push;
   entry_type entry_in;
   entry_type entry_out;
   logic      entry_full;
   logic      entry_empty;
   logic      entry_pop;
   logic      restart;
   logic      back_push;
   rsp_type   back_rsp;
   rsp_type   out_rsp;
   logic      out_full;
   logic      clearing;

   assign req_full = clearing || entry_full;
   assign accept   = req_push && !req_full;

   xsed_front #(
      .MAX_OBJECTS     (MAX_OBJECTS),
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (accept),
      .data_byte  (req_data_byte),
      .entry_push (entry_push),
      .entry      (entry_in),
      .restart    (restart)
   );

   xsed_fifo #(
      .WIDTH ($bits(entry_type))
   ) u_entry_q (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry_in),
      .full      (entry_full),
      .pop       (entry_pop),
      .pop_data  (entry_out),
      .empty     (entry_empty)
   );

   xsed_back #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .ent_valid (!entry_empty),
      .ent       (entry_out),
      .ent_pop   (entry_pop),
      .rsp_push  (back_push),
      .rsp       (back_rsp),
      .rsp_full  (out_full),
      .clearing  (clearing)
   );

   xsed_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_object_number = out_rsp.object_number;
   assign rsp_entry_kind    = out_rsp.entry_kind;
   assign rsp_second_value  = out_rsp.second_value;
   assign rsp_third_value   = out_rsp.third_value;
   assign rsp_status        = out_rsp.status;
   assign rsp_section_end   = out_rsp.section_end;

endmodule
`default_nettype wire
